>>> design/samu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// samu_pkg
// Shared types and constants for the stepper axis home and move unit.
// ----------------------------------------------------------------------------
package samu_pkg;

	// Microsteps issued per millimetre of travel
	localparam logic [7:0] MICROSTEPS_PER_MM = 8'd200;

	// Configuration register reset values
	localparam logic [15:0] HOME_HALF_RESET = 16'd500;
	localparam logic [15:0] MOVE_HALF_RESET = 16'd100;

	// Microstep select code for eighth step
	localparam logic [1:0] MS_EIGHTH = 2'd3;

	// Configuration register indexes
	typedef enum logic {
		CFG_HOME_HALF = 1'b0,
		CFG_MOVE_HALF = 1'b1
	} cfg_index_t;

	// Item actions
	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_HOME = 2'd1,
		ACT_MOVE = 2'd2
	} action_t;

	// Axis mode
	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_HOME = 2'd1,
		MODE_MOVE = 2'd2
	} mode_t;

	// Input beat
	typedef struct packed {
		logic [1:0] action;
		logic [7:0] goal_mm;
		logic       switch_closed;
	} in_item_t;

	// Result beat
	typedef struct packed {
		logic       step_level;
		logic       dir_level;
		logic       enable_n;
		logic [1:0] microstep_sel;
		logic       busy_res;
		logic [7:0] position_mm;
		logic       rejected;
	} out_item_t;

	// Axis state
	typedef struct packed {
		mode_t       mode;
		logic [7:0]  position;
		logic [15:0] steps_remaining;
		logic [15:0] phase_timer;
		logic        step_pin;
		logic        dir_pin;
		logic        driver_enabled;
		logic [1:0]  ms_pins;
	} axis_state_t;

	localparam axis_state_t AXIS_RESET = '{
		mode:            MODE_IDLE,
		position:        8'd0,
		steps_remaining: 16'd0,
		phase_timer:     16'd0,
		step_pin:        1'b0,
		dir_pin:         1'b0,
		driver_enabled:  1'b0,
		ms_pins:         2'd0
	};

endpackage
`default_nettype wire

>>> design/samu_next.sv
`default_nettype none
// ----------------------------------------------------------------------------
// samu_next
// Next-state logic of the axis: pulse timing, homing, move setup, reject.
// ----------------------------------------------------------------------------
module samu_next
	import samu_pkg::*;
(
	input  var axis_state_t cur,
	input  var in_item_t    item,
	input  var logic [15:0] home_half,
	input  var logic [15:0] move_half,
	output axis_state_t     nxt,
	output logic            rejected
);

	logic [15:0] half_raw;
	logic [15:0] half;
	logic [15:0] timer_dec;
	logic [7:0]  diff;
	logic        goal_below;
	logic [15:0] move_steps;

	// Pick the half period for the current mode; zero acts as one
	assign half_raw = (cur.mode == MODE_HOME) ? home_half : move_half;
	assign half     = (half_raw == 16'd0) ? 16'd1 : half_raw;

	assign timer_dec = (cur.phase_timer != 16'd0) ? cur.phase_timer - 16'd1 : 16'd0;

	// Distance to goal in whole millimetres and its microstep count
	assign goal_below = item.goal_mm < cur.position;
	assign diff       = goal_below ? cur.position - item.goal_mm : item.goal_mm - cur.position;
	assign move_steps = 16'(diff) * 16'(MICROSTEPS_PER_MM);

	always_comb begin
		nxt      = cur;
		rejected = 1'b0;
		case (item.action)
			ACT_TICK: begin
				// Advance the pulse timer while busy
				if (cur.mode != MODE_IDLE) begin
					nxt.phase_timer = timer_dec;
					if (timer_dec == 16'd0) begin
						if (cur.step_pin) begin
							nxt.step_pin    = 1'b0;
							nxt.phase_timer = half;
						end else if (cur.mode == MODE_HOME) begin
							if (item.switch_closed) begin
								nxt.position = 8'd0;
								nxt.mode     = MODE_IDLE;
							end else begin
								nxt.step_pin    = 1'b1;
								nxt.phase_timer = half;
							end
						end else if (cur.steps_remaining == 16'd0) begin
							nxt.mode = MODE_IDLE;
						end else begin
							nxt.steps_remaining = cur.steps_remaining - 16'd1;
							nxt.step_pin        = 1'b1;
							nxt.phase_timer     = half;
						end
					end
				end
			end
			ACT_HOME, ACT_MOVE: begin
				if (cur.mode != MODE_IDLE) begin
					rejected = 1'b1;
				end else begin
					// Prepare the driver for a new run
					nxt.ms_pins        = MS_EIGHTH;
					nxt.driver_enabled = 1'b1;
					nxt.step_pin       = 1'b0;
					nxt.phase_timer    = 16'd0;
					if (item.action == ACT_HOME) begin
						nxt.dir_pin = 1'b0;
						nxt.mode    = MODE_HOME;
					end else begin
						nxt.dir_pin         = !goal_below;
						nxt.steps_remaining = move_steps;
						nxt.position        = item.goal_mm;
						if (move_steps != 16'd0) begin
							nxt.mode = MODE_MOVE;
						end
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> design/stepper_axis_home_and_move_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_axis_home_and_move_unit
// Single-axis step/direction generator with homing for an eighth-step driver.
// ----------------------------------------------------------------------------
// Every input beat yields exactly one result beat. An item is accepted in any
// cycle in which the two-entry result buffer has room, so the sustained rate
// is one item per clock. Each result is registered in the output register;
// a stalled result is held there and one more result fits in a skid register
// before in_stall rises. Half-period registers are written through the plain
// write port; the user must write them only while the block is idle, as the
// block itself does not enforce this.
module stepper_axis_home_and_move_unit
	import samu_pkg::*;
(
	input  var logic      clk,
	input  var logic      arst_n,
	input  var logic      cfg_we,
	input  var logic      cfg_index,
	input  var logic [15:0] cfg_data,
	input  var logic      in_valid,
	output logic          in_stall,
	input  var in_item_t  in_data,
	output logic          out_valid,
	input  var logic      out_stall,
	output out_item_t     out_data
);

	logic [15:0] home_half_q;
	logic [15:0] move_half_q;
	axis_state_t state_q;
	axis_state_t state_nxt;
	logic        rej;
	out_item_t   result;
	logic        in_take;
	logic        out_free;
	logic        out_valid_q;
	out_item_t   out_data_q;
	logic        skid_valid_q;
	out_item_t   skid_data_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_half_q <= HOME_HALF_RESET;
			move_half_q <= MOVE_HALF_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HOME_HALF: home_half_q <= cfg_data;
				CFG_MOVE_HALF: move_half_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	samu_next u_next (
		.cur       (state_q),
		.item      (in_data),
		.home_half (home_half_q),
		.move_half (move_half_q),
		.nxt       (state_nxt),
		.rejected  (rej)
	);

	// Build the result beat from the updated state
	always_comb begin
		result.step_level    = state_nxt.step_pin;
		result.dir_level     = state_nxt.dir_pin;
		result.enable_n      = !state_nxt.driver_enabled;
		result.microstep_sel = state_nxt.ms_pins;
		result.busy_res      = state_nxt.mode != MODE_IDLE;
		result.position_mm   = state_nxt.position;
		result.rejected      = rej;
	end

	assign in_stall = skid_valid_q;
	assign in_take  = in_valid && !skid_valid_q;
	assign out_free = !out_valid_q || !out_stall;

	// Commit axis state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AXIS_RESET;
		end else if (in_take) begin
			state_q <= state_nxt;
		end
	end

	// Output register and skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || in_take;
			skid_valid_q <= 1'b0;
		end else if (in_take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : result;
		end
		if (!out_free && in_take) begin
			skid_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Skid only holds a beat behind a waiting output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a beat with the output register empty");

	// Skid fills only after a stalled output
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid filled without an output stall");

	// A rejected command is only reported while busy
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.rejected |-> out_data_q.busy_res)
		else $error("rejected beat reported while idle");

	// A busy axis always has the driver enabled at eighth step
	a_busy_driver: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode != MODE_IDLE |-> state_q.driver_enabled && state_q.ms_pins == MS_EIGHTH)
		else $error("axis busy with driver not prepared");

	// An idle axis leaves the step pin low
	a_idle_step_low: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == MODE_IDLE |-> !state_q.step_pin)
		else $error("step pin high while idle");

endmodule
`default_nettype wire
